>>> design/mfde_pkg.sv
// Package for the monochrome framebuffer draw engine.
// Holds payload structs, action codes and the 5x7 font lookup; no dependencies.
package mfde_pkg;

	typedef enum logic [2:0] {
		ACT_CLEAR = 3'd0,
		ACT_PIXEL = 3'd1,
		ACT_GLYPH = 3'd2,
		ACT_TEXT  = 3'd3,
		ACT_BAR   = 3'd4,
		ACT_READ  = 3'd5
	} action_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic       pix_set;
		logic [7:0] char_code;
		logic       new_text;
		logic [7:0] bar_width;
		logic [7:0] bar_height;
		logic [7:0] percent;
		logic [9:0] byte_index;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       drawn;
	} res_t;

	localparam logic [2:0] GLYPH_W    = 3'd5;
	localparam logic [2:0] GLYPH_H    = 3'd7;
	localparam logic [7:0] GLYPH_STEP = 8'd6;
	localparam logic [7:0] PCT_MAX    = 8'd100;

	function automatic logic [39:0] font_lookup(input logic [7:0] code);
		logic [39:0] g;
		case (code)
			8'h2D: g = 40'h08_08_08_08_08;
			8'h3A: g = 40'h00_00_36_00_00;
			8'h2E: g = 40'h00_00_60_00_00;
			8'h30: g = 40'h3E_51_49_45_3E;
			8'h31: g = 40'h00_42_7F_40_00;
			8'h32: g = 40'h42_61_51_49_46;
			8'h33: g = 40'h41_49_49_49_36;
			8'h34: g = 40'h18_14_12_7F_10;
			8'h35: g = 40'h4F_49_49_49_31;
			8'h36: g = 40'h3E_49_49_49_30;
			8'h37: g = 40'h01_71_09_05_03;
			8'h38: g = 40'h36_49_49_49_36;
			8'h39: g = 40'h06_49_49_49_3E;
			8'h41: g = 40'h7E_09_09_09_7E;
			8'h42: g = 40'h7F_49_49_49_36;
			8'h43: g = 40'h3E_41_41_41_22;
			8'h44: g = 40'h7F_41_41_41_3E;
			8'h45: g = 40'h7F_49_49_49_41;
			8'h46: g = 40'h7F_09_09_09_01;
			8'h47: g = 40'h3E_41_49_49_3A;
			8'h48: g = 40'h7F_08_08_08_7F;
			8'h49: g = 40'h00_41_7F_41_00;
			8'h4A: g = 40'h30_40_41_3F_01;
			8'h4B: g = 40'h7F_08_14_22_41;
			8'h4C: g = 40'h7F_40_40_40_40;
			8'h4D: g = 40'h7F_02_0C_02_7F;
			8'h4E: g = 40'h7F_02_04_08_7F;
			8'h4F: g = 40'h3E_41_41_41_3E;
			8'h50: g = 40'h7F_09_09_09_06;
			8'h51: g = 40'h3E_41_51_21_5E;
			8'h52: g = 40'h7F_09_19_29_46;
			8'h53: g = 40'h46_49_49_49_31;
			8'h54: g = 40'h01_01_7F_01_01;
			8'h55: g = 40'h3F_40_40_40_3F;
			8'h56: g = 40'h1F_20_40_20_1F;
			8'h57: g = 40'h3F_40_38_40_3F;
			8'h58: g = 40'h63_14_08_14_63;
			8'h59: g = 40'h03_04_78_04_03;
			8'h5A: g = 40'h61_51_49_45_43;
			default: g = 40'h0;
		endcase
		return g;
	endfunction

endpackage

>>> design/mono_framebuffer_draw_engine.sv
// Top level: command sequencer for the monochrome framebuffer draw engine.
// Depends on mfde_pkg and mfde_store.
//  channel | ports                    | rule
//  command | start, busy, cmd         | transfer when start && !busy
//  result  | done, res                | one cycle strobe, no stall
// Each pixel is a read, then a write, through the single store port; a
// pixel's write is done before the next pixel's read. Glyph/text: 42
// pixels. Bar: 2*w+2*h+(w-2)*(h-2) pixels. Clear and reset sweep the
// whole store, one byte per cycle.
// Reset holds busy until the clearing sweep ends. The receiver cannot stall.
module mono_framebuffer_draw_engine
	import mfde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t res
);
	localparam int DEPTH = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
	localparam int AW    = $clog2(DEPTH);
	localparam logic [28:0] FILL_RECIP = 29'd5243;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_PX, S_PXW, S_READ, S_GLY, S_BAR_O, S_BAR_I, S_DONE
	} state_t;

	state_t      state_q;
	cmd_t        cmd_q;
	logic [7:0]  cx_q, cy_q;
	logic [7:0]  ox_q, oy_q;
	logic [7:0]  i_q, j_q;
	logic [1:0]  side_q;
	logic        ph_q;
	logic [39:0] glyph_q;
	logic [15:0] prod_q;
	logic [7:0]  fill_q;
	logic        ok_q;
	logic [7:0]  data_q;
	logic        done_q;

	logic        clr_start, clr_busy, px_valid, px_on, px_hit, rd_valid;
	logic [7:0]  px_x, px_y, rd_data;
	logic [15:0] fill_prod;
	logic [28:0] fill_mul;
	logic [7:0]  pct_sat;
	logic [7:0]  gcol;

	assign pct_sat   = (cmd.percent > PCT_MAX) ? PCT_MAX : cmd.percent;
	assign fill_prod = 16'(cmd.bar_width - 8'd2) * 16'(pct_sat) + 16'd50;
	assign fill_mul  = 29'(prod_q) * FILL_RECIP;
	assign gcol      = glyph_q[8*(4 - int'(i_q[2:0])) +: 8];

	mfde_store #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_store (
		.clk, .arst_n, .clr_start, .clr_busy, .px_valid, .px_x, .px_y, .px_on,
		.px_hit, .rd_valid, .rd_addr(AW'(cmd_q.byte_index)), .rd_data
	);

	always_comb begin
		px_valid = 1'b0;
		px_x     = ox_q + i_q;
		px_y     = oy_q + j_q;
		px_on    = 1'b0;
		rd_valid = (state_q == S_READ);
		clr_start = (state_q == S_IDLE) && start && !clr_busy &&
			(cmd.action == ACT_CLEAR);
		unique case (state_q)
			S_PX: begin
				px_valid = !ph_q;
				px_x     = cmd_q.pos_x;
				px_y     = cmd_q.pos_y;
				px_on    = cmd_q.pix_set;
			end
			S_GLY: begin
				px_valid = !ph_q;
				px_on    = (i_q < 8'(GLYPH_W)) && gcol[j_q[2:0]];
			end
			S_BAR_O: begin
				px_valid = !ph_q;
				px_on    = 1'b1;
			end
			S_BAR_I: begin
				px_valid = !ph_q;
				px_on    = i_q <= fill_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			ox_q    <= '0;
			oy_q    <= '0;
			i_q     <= '0;
			j_q     <= '0;
			side_q  <= '0;
			glyph_q <= '0;
			prod_q  <= '0;
			fill_q  <= '0;
			ok_q    <= 1'b0;
			data_q  <= '0;
			done_q  <= 1'b0;
			ph_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			ph_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start && !clr_busy) begin
					cmd_q  <= cmd;
					ok_q   <= 1'b0;
					data_q <= '0;
					i_q    <= '0;
					j_q    <= '0;
					side_q <= '0;
					ox_q   <= cmd.pos_x;
					oy_q   <= cmd.pos_y;
					glyph_q <= font_lookup(cmd.char_code);
					prod_q <= fill_prod;
					case (cmd.action)
						ACT_CLEAR: begin ok_q <= 1'b1; state_q <= S_CLR; end
						ACT_PIXEL: state_q <= S_PX;
						ACT_GLYPH: begin ok_q <= 1'b1; state_q <= S_GLY; end
						ACT_TEXT: begin
							if ((cmd.new_text ? cmd.pos_x : cx_q) <=
									8'(SCREEN_WIDTH) - GLYPH_STEP &&
									(cmd.new_text ? cmd.pos_y : cy_q) <=
									8'(SCREEN_HEIGHT) - 8'(GLYPH_H)) begin
								ok_q    <= 1'b1;
								ox_q    <= cmd.new_text ? cmd.pos_x : cx_q;
								oy_q    <= cmd.new_text ? cmd.pos_y : cy_q;
								cx_q    <= (cmd.new_text ? cmd.pos_x : cx_q) + GLYPH_STEP;
								cy_q    <= cmd.new_text ? cmd.pos_y : cy_q;
								state_q <= S_GLY;
							end else begin
								if (cmd.new_text) begin
									cx_q <= cmd.pos_x;
									cy_q <= cmd.pos_y;
								end
								state_q <= S_DONE;
							end
						end
						ACT_BAR: begin
							if (cmd.bar_width >= 8'd3 && cmd.bar_height >= 8'd3 &&
									cmd.pos_x < 8'(SCREEN_WIDTH) &&
									cmd.pos_y < 8'(SCREEN_HEIGHT)) begin
								ok_q    <= 1'b1;
								state_q <= S_BAR_O;
							end else
								state_q <= S_DONE;
						end
						ACT_READ: state_q <= S_READ;
						default: state_q <= S_DONE;
					endcase
				end
				S_CLR: if (!clr_busy) state_q <= S_DONE;
				S_PX: begin
					ok_q    <= px_hit;
					ph_q    <= 1'b1;
					state_q <= ph_q ? S_DONE : S_PX;
				end
				S_READ: state_q <= S_PXW;
				S_PXW: begin
					if (32'(cmd_q.byte_index) < DEPTH) begin
						data_q <= rd_data;
						ok_q   <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_GLY: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (j_q == 8'(GLYPH_H) - 8'd1) begin
							j_q <= '0;
							if (i_q == 8'(GLYPH_W)) state_q <= S_DONE;
							else i_q <= i_q + 8'd1;
						end else
							j_q <= j_q + 8'd1;
					end
				end
				S_BAR_O: begin
					ph_q   <= !ph_q;
					fill_q <= fill_mul[26:19];
					if (ph_q) begin
						unique case (side_q)
							2'd0, 2'd1: begin
								if (i_q == cmd_q.bar_width - 8'd1) begin
									i_q    <= (side_q == 2'd0) ? '0 : '0;
									j_q    <= (side_q == 2'd0) ? cmd_q.bar_height - 8'd1 : '0;
									side_q <= side_q + 2'd1;
								end else
									i_q <= i_q + 8'd1;
								if (side_q == 2'd0 && i_q != cmd_q.bar_width - 8'd1)
									j_q <= '0;
							end
							2'd2, 2'd3: begin
								if (j_q == cmd_q.bar_height - 8'd1) begin
									if (side_q == 2'd2) begin
										j_q    <= '0;
										i_q    <= cmd_q.bar_width - 8'd1;
										side_q <= 2'd3;
									end else begin
										i_q     <= 8'd1;
										j_q     <= 8'd1;
										state_q <= (cmd_q.bar_height > 8'd2 &&
											cmd_q.bar_width > 8'd2) ? S_BAR_I : S_DONE;
									end
								end else
									j_q <= j_q + 8'd1;
							end
							default: ;
						endcase
					end
				end
				S_BAR_I: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (i_q == cmd_q.bar_width - 8'd2) begin
							i_q <= 8'd1;
							if (j_q == cmd_q.bar_height - 8'd2) state_q <= S_DONE;
							else j_q <= j_q + 8'd1;
						end else
							i_q <= i_q + 8'd1;
					end
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE) || clr_busy;
	assign done          = done_q;
	assign res.read_data = data_q;
	assign res.drawn     = ok_q;
endmodule

>>> design/mfde_store.sv
// Framebuffer byte store with a single read-modify-write pixel port.
// Depends on mfde_pkg; a clearing sweep runs after reset and on request.
module mfde_store
	import mfde_pkg::*;
#(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clr_start,
	output logic                    clr_busy,
	input  logic                    px_valid,
	input  logic [7:0]              px_x,
	input  logic [7:0]              px_y,
	input  logic                    px_on,
	output logic                    px_hit,
	input  logic                    rd_valid,
	input  logic [$clog2(SCREEN_WIDTH*((SCREEN_HEIGHT+7)/8))-1:0] rd_addr,
	output logic [7:0]              rd_data
);
	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int DEPTH = SCREEN_WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [AW:0]   clr_q;
	logic          clr_busy_q;
	logic [AW-1:0] px_addr;
	logic [AW-1:0] wr_addr_q;
	logic [7:0]    wr_mask_q;
	logic          wr_on_q;
	logic          wr_pend_q;
	logic [7:0]    cur;

	assign px_hit   = (px_x < 8'(SCREEN_WIDTH)) && (px_y < 8'(SCREEN_HEIGHT));
	assign px_addr  = AW'(px_x) + AW'(px_y[7:3]) * AW'(SCREEN_WIDTH);
	assign clr_busy = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
			wr_pend_q  <= 1'b0;
		end else begin
			wr_pend_q <= px_valid && px_hit && !clr_busy_q;
			if (clr_start) begin
				clr_busy_q <= 1'b1;
				clr_q      <= '0;
			end else if (clr_busy_q) begin
				if (clr_q == (AW+1)'(DEPTH - 1))
					clr_busy_q <= 1'b0;
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= px_addr;
		wr_mask_q <= 8'(1) << px_y[2:0];
		wr_on_q   <= px_on;
		cur       <= mem[rd_valid ? rd_addr : px_addr];
		if (clr_busy_q)
			mem[clr_q[AW-1:0]] <= 8'h00;
		else if (wr_pend_q)
			mem[wr_addr_q] <= wr_on_q ? (cur | wr_mask_q) : (cur & ~wr_mask_q);
	end

	assign rd_data = cur;
endmodule

>>> tb/tb.sv
// Self-checking testbench for mono_framebuffer_draw_engine.
// Uses mfde_pkg types. Runs a directed table, then random commands, checking
// each result against a table value or a model of framebuffer and text cursor.
module tb
	import mfde_pkg::*;
();

	localparam int WID = 128;
	localparam int HGT = 64;
	localparam int BYTES = WID * ((HGT + 7) / 8);
	localparam int ROWS = 22;

	localparam logic [7:0] FONT_CODE [40] = '{
		8'h20, 8'h2D, 8'h3A, 8'h2E, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
		8'h36, 8'h37, 8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46,
		8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
		8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A};
	localparam logic [39:0] FONT_BITS [40] = '{
		40'h0000000000, 40'h0808080808, 40'h0000360000, 40'h0000600000,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h4149494936,
		40'h1814127F10, 40'h4F49494931, 40'h3E49494930, 40'h0171090503,
		40'h3649494936, 40'h064949493E, 40'h7E0909097E, 40'h7F49494936,
		40'h3E41414122, 40'h7F4141413E, 40'h7F49494941, 40'h7F09090901,
		40'h3E4149493A, 40'h7F0808087F, 40'h00417F4100, 40'h3040413F01,
		40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0204087F,
		40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
		40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
		40'h3F4038403F, 40'h6314081463, 40'h0304780403, 40'h6151494543};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	res_t res;

	logic [7:0] pixels [BYTES];
	logic [7:0] cur_x;
	logic [7:0] cur_y;
	res_t pending [$];
	int errors;

	mono_framebuffer_draw_engine #(.SCREEN_WIDTH(WID), .SCREEN_HEIGHT(HGT)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .res(res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic bit plot(int x, int y, bit on);
		int px;
		int py;
		int idx;
		px = x & 255;
		py = y & 255;
		if (px >= WID || py >= HGT)
			return 1'b0;
		idx = px + (py / 8) * WID;
		pixels[idx][py % 8] = on;
		return 1'b1;
	endfunction

	function automatic void glyph(int x, int y, logic [7:0] code);
		logic [39:0] bits;
		logic [7:0] col;
		bit unused;
		bits = '0;
		for (int i = 0; i < 40; i++)
			if (FONT_CODE[i] == code)
				bits = FONT_BITS[i];
		for (int c = 0; c < 5; c++) begin
			col = bits[39 - 8 * c -: 8];
			for (int r = 0; r < 7; r++)
				unused = plot(x + c, y + r, col[r]);
		end
		for (int r = 0; r < 7; r++)
			unused = plot(x + 5, y + r, 1'b0);
	endfunction

	function automatic bit bar(int x, int y, int w, int h, int pct);
		int fill;
		bit unused;
		if (w < 3 || h < 3 || x >= WID || y >= HGT)
			return 1'b0;
		if (pct > 100)
			pct = 100;
		for (int i = 0; i < w; i++) begin
			unused = plot(x + i, y, 1'b1);
			unused = plot(x + i, y + h - 1, 1'b1);
		end
		for (int j = 0; j < h; j++) begin
			unused = plot(x, y + j, 1'b1);
			unused = plot(x + w - 1, y + j, 1'b1);
		end
		fill = ((w - 2) * pct + 50) / 100;
		for (int j = 1; j < h - 1; j++)
			for (int i = 1; i < w - 1; i++)
				unused = plot(x + i, y + j, i <= fill);
		return 1'b1;
	endfunction

	function automatic res_t apply_cmd(cmd_t c);
		res_t r;
		r = '0;
		case (c.action)
			ACT_CLEAR: begin
				foreach (pixels[i])
					pixels[i] = '0;
				r.drawn = 1'b1;
			end
			ACT_PIXEL: r.drawn = plot(c.pos_x, c.pos_y, c.pix_set);
			ACT_GLYPH: begin
				glyph(c.pos_x, c.pos_y, c.char_code);
				r.drawn = 1'b1;
			end
			ACT_TEXT: begin
				if (c.new_text) begin
					cur_x = c.pos_x;
					cur_y = c.pos_y;
				end
				if (cur_x <= WID - 6 && cur_y <= HGT - 7) begin
					glyph(cur_x, cur_y, c.char_code);
					cur_x = cur_x + GLYPH_STEP;
					r.drawn = 1'b1;
				end
			end
			ACT_BAR: r.drawn = bar(c.pos_x, c.pos_y, c.bar_width, c.bar_height, c.percent);
			ACT_READ: begin
				if (c.byte_index < BYTES) begin
					r.read_data = pixels[c.byte_index];
					r.drawn = 1'b1;
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [8:0] got, logic [8:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				report("unexpected result", res, '0);
			end else begin
				res_t want;
				want = pending.pop_front();
				if (res.read_data !== want.read_data)
					report("read_data", 9'(res.read_data), 9'(want.read_data));
				if (res.drawn !== want.drawn)
					report("drawn", 9'(res.drawn), 9'(want.drawn));
			end
		end
	end

	task automatic issue(cmd_t c, bit known, res_t want);
		int gap;
		res_t got;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		got = apply_cmd(c);
		pending.push_back(known ? want : got);
	endtask

	function automatic cmd_t mk(action_t a, int x, int y, int code, int nt,
		int w, int h, int pct, int idx, int on);
		cmd_t c;
		c = '0;
		c.action = a;
		c.pos_x = 8'(x);
		c.pos_y = 8'(y);
		c.char_code = 8'(code);
		c.new_text = 1'(nt);
		c.bar_width = 8'(w);
		c.bar_height = 8'(h);
		c.percent = 8'(pct);
		c.byte_index = 10'(idx);
		c.pix_set = 1'(on);
		return c;
	endfunction

	function automatic cmd_t rand_cmd(int k);
		cmd_t c;
		logic [63:0] raw;
		int sel;
		raw = {$urandom(), $urandom()};
		c = raw[$bits(cmd_t)-1:0];
		sel = $urandom_range(0, 99);
		if (sel < 2)
			c.action = ACT_CLEAR;
		else if (sel < 22)
			c.action = ACT_PIXEL;
		else if (sel < 34)
			c.action = ACT_GLYPH;
		else if (sel < 56)
			c.action = ACT_TEXT;
		else if (sel < 68)
			c.action = ACT_BAR;
		else if (sel < 96)
			c.action = ACT_READ;
		else
			c.action = action_t'($urandom_range(6, 7));
		if ($urandom_range(0, 3) != 0) begin
			c.pos_x = 8'($urandom_range(0, WID - 1));
			c.pos_y = 8'($urandom_range(0, HGT - 1));
		end
		if (c.action == ACT_TEXT) begin
			c.new_text = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 4) != 0)
				c.char_code = FONT_CODE[$urandom_range(0, 39)];
		end
		if (c.action == ACT_GLYPH && $urandom_range(0, 2) != 0)
			c.char_code = FONT_CODE[$urandom_range(0, 39)];
		if (c.action == ACT_BAR && k % 100 != 7) begin
			c.bar_width = 8'($urandom_range(0, 30));
			c.bar_height = 8'($urandom_range(0, 20));
			c.percent = ($urandom_range(0, 3) == 0) ? 8'($urandom())
				: 8'($urandom_range(0, 100));
		end
		return c;
	endfunction

	initial begin
		cmd_t rows [ROWS];
		res_t want_row [ROWS];
		bit known_row [ROWS];
		res_t none;

		errors = 0;
		start = 1'b0;
		cmd = '0;
		none = '0;
		foreach (pixels[i])
			pixels[i] = '0;
		cur_x = '0;
		cur_y = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		rows[0] = mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		want_row[0] = '{8'h00, 1'b1};
		rows[1] = mk(ACT_PIXEL, 127, 63, 0, 0, 0, 0, 0, 0, 1);
		want_row[1] = '{8'h00, 1'b1};
		rows[2] = mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 1023, 0);
		want_row[2] = '{8'h80, 1'b1};
		rows[3] = mk(ACT_PIXEL, 128, 0, 0, 0, 0, 0, 0, 0, 1);
		want_row[3] = '{8'h00, 1'b0};
		rows[4] = mk(ACT_PIXEL, 255, 255, 0, 0, 0, 0, 0, 0, 1);
		want_row[4] = '{8'h00, 1'b0};
		rows[5] = mk(ACT_GLYPH, 0, 0, 8'h41, 0, 0, 0, 0, 0, 0);
		want_row[5] = '{8'h00, 1'b1};
		rows[6] = mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		want_row[6] = '{8'h7E, 1'b1};
		rows[7] = mk(ACT_GLYPH, 250, 60, 8'hFF, 0, 0, 0, 0, 0, 0);
		want_row[7] = '{8'h00, 1'b1};
		rows[8] = mk(ACT_TEXT, 0, 8, 8'h5A, 1, 0, 0, 0, 0, 0);
		want_row[8] = '{8'h00, 1'b1};
		rows[9] = mk(ACT_TEXT, 0, 0, 8'h30, 0, 0, 0, 0, 0, 0);
		rows[10] = mk(ACT_TEXT, 123, 0, 8'h31, 1, 0, 0, 0, 0, 0);
		want_row[10] = '{8'h00, 1'b0};
		rows[11] = mk(ACT_TEXT, 122, 57, 8'h2E, 1, 0, 0, 0, 0, 0);
		want_row[11] = '{8'h00, 1'b1};
		rows[12] = mk(ACT_TEXT, 0, 0, 8'h20, 0, 0, 0, 0, 0, 0);
		want_row[12] = '{8'h00, 1'b0};
		rows[13] = mk(ACT_BAR, 10, 10, 0, 0, 2, 10, 50, 0, 0);
		want_row[13] = '{8'h00, 1'b0};
		rows[14] = mk(ACT_BAR, 10, 10, 0, 0, 10, 2, 50, 0, 0);
		want_row[14] = '{8'h00, 1'b0};
		rows[15] = mk(ACT_BAR, 128, 0, 0, 0, 10, 10, 50, 0, 0);
		want_row[15] = '{8'h00, 1'b0};
		rows[16] = mk(ACT_BAR, 20, 20, 0, 0, 12, 6, 0, 0, 0);
		rows[17] = mk(ACT_BAR, 0, 0, 0, 0, 255, 255, 255, 0, 0);
		want_row[17] = '{8'h00, 1'b1};
		rows[18] = mk(action_t'(3'd6), 1, 1, 0, 0, 0, 0, 0, 0, 1);
		want_row[18] = '{8'h00, 1'b0};
		rows[19] = mk(action_t'(3'd7), 1, 1, 0, 0, 0, 0, 0, 0, 1);
		want_row[19] = '{8'h00, 1'b0};
		rows[20] = mk(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		want_row[20] = '{8'h00, 1'b1};
		rows[21] = mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 1023, 0);
		want_row[21] = '{8'h00, 1'b1};
		foreach (known_row[i])
			known_row[i] = !(i == 9 || i == 16);

		for (int i = 0; i < ROWS; i++)
			issue(rows[i], known_row[i], want_row[i]);

		for (int k = 0; k < 500; k++) begin
			if (k == 250) begin
				start <= 1'b0;
				while (pending.size() != 0)
					@(posedge clk);
			end
			issue(rand_cmd(k), 1'b0, none);
		end
		start <= 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
